// ===== hw/rtl/chc_pkg.sv =====
// ----------------------------------------------------------------------------
// chc_pkg
// Shared constants and codes for the canonical Huffman table engine.
// ----------------------------------------------------------------------------
package chc_pkg;

  localparam int SymbolsDef  = 256;
  localparam int MaxBitsDef  = 16;
  localparam int CodeW       = 16;
  localparam int SymW        = 8;
  localparam int LenW        = 5;
  localparam int NumSymW     = 9;
  localparam logic [NumSymW-1:0] NumSymRst = 9'd256;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_ENCODE = 2'd2,
    OP_DECODE = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_ENC  = 2'd0,
    KIND_SYM  = 2'd1,
    KIND_FAIL = 2'd2
  } kind_e;

endpackage

// ===== hw/rtl/chc_ram.sv =====
// ----------------------------------------------------------------------------
// chc_ram
// Single write port, single registered read port table storage.
// ----------------------------------------------------------------------------
module chc_ram #(
  parameter int Depth = 256,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/canonical_huffman_codec.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_codec
// Canonical Huffman engine: load lengths, build tables, encode, decode.
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid/ready, op, symbol, length, bit_req | to block
//  out     | out_valid/ready, kind, decoded_symbol, code, code_len | from block
//  cfg     | cfg_valid/ready, cfg_data (num_symbols)   | to block
//
//  Load, decode without result and decode failure end in idle; encode and
//  decoded symbol pass via ST_ENC or ST_DEC. Build reads the used length
//  entries once per code length, one per cycle. A clear pass after reset
//  zeroes all SYMBOLS length and code entries; no input word is taken then.
//  A new word waits until the previous result word has left the output register.
// ----------------------------------------------------------------------------
module canonical_huffman_codec
  import chc_pkg::*;
#(
  parameter int SYMBOLS     = SymbolsDef,
  parameter int MaxCodeBits = MaxBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic [SymW-1:0]    symbol_i,
  input  logic [LenW-1:0]    length_i,
  input  logic               bit_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [SymW-1:0]    decoded_symbol_o,
  output logic [CodeW-1:0]   code_o,
  output logic [LenW-1:0]    code_len_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [NumSymW-1:0] cfg_data_i
);

  localparam int AW = $clog2(SYMBOLS);
  localparam int CW = $clog2(SYMBOLS + 1);
  localparam int NW = (CW > NumSymW) ? CW : NumSymW;
  localparam int LW = $clog2(MaxCodeBits + 1);
  localparam int IW = $clog2(MaxCodeBits);
  localparam int SW = ((CW > CodeW) ? CW : CodeW) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_ENC, ST_SCAN, ST_DEC
  } state_e;

  state_e state_q, state_d;

  logic [NumSymW-1:0] num_q;
  logic [AW-1:0]      clr_q, clr_d;
  logic [NW-1:0]      s_q, s_d;
  logic               rd_v_q, rd_v_d;
  logic [AW-1:0]      rd_sym_q, rd_sym_d;
  logic [IW-1:0]      len_idx_q, len_idx_d;
  logic [CodeW-1:0]   cur_q, cur_d;
  logic [CodeW-1:0]   first_cur_q, first_cur_d;
  logic [CW-1:0]      cnt_cur_q, cnt_cur_d;
  logic [CW-1:0]      base_cur_q, base_cur_d;
  logic [CW-1:0]      placed_q, placed_d;
  logic [CodeW-1:0]   gc_q, gc_d;
  logic [IW-1:0]      gb_q, gb_d;
  logic               enc_ok_q, enc_ok_d;

  logic [CodeW-1:0] first_q [MaxCodeBits];
  logic [CW-1:0]    count_q [MaxCodeBits];
  logic [CW-1:0]    base_q  [MaxCodeBits];
  logic             tab_we;

  logic             out_valid_q, out_valid_d;
  logic [1:0]       kind_q, kind_d;
  logic [SymW-1:0]  dsym_q, dsym_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [LenW-1:0]  clen_q, clen_d;

  logic          len_we;
  logic [AW-1:0] len_waddr, len_raddr;
  logic [LW-1:0] len_wdata, len_rdata;
  logic          code_we;
  logic [AW-1:0] code_waddr;
  logic [CodeW-1:0] code_wdata, code_rdata;
  logic          srt_we;
  logic [SymW-1:0] srt_rdata;
  logic [AW-1:0] srt_raddr;

  logic [NW-1:0]    num_ext, n_eff, sym_ext;
  logic             sym_ok, in_fire, hit;
  logic [AW-1:0]    sym_addr;
  logic [LW-1:0]    len_val;
  logic [CodeW-1:0] gc_n, f_sel, diff;
  logic             match;
  logic [SW-1:0]    pos_sum;

  assign num_ext  = NW'(num_q);
  assign n_eff    = (num_ext < NW'(SYMBOLS)) ? num_ext : NW'(SYMBOLS);
  assign sym_ext  = NW'(symbol_i);
  assign sym_ok   = sym_ext < n_eff;
  assign sym_addr = sym_ext[AW-1:0];
  assign in_fire  = in_valid_i && in_ready_o;
  assign len_val  = LW'(len_idx_q) + LW'(1);
  assign hit      = (state_q == ST_SCAN) && rd_v_q && (len_rdata == len_val);

  assign gc_n    = {gc_q[CodeW-2:0], bit_req_i};
  assign f_sel   = first_q[gb_q];
  assign diff    = gc_n - f_sel;
  assign match   = (gc_n >= f_sel) && (SW'(diff) < SW'(count_q[gb_q]));
  assign pos_sum = SW'(base_q[gb_q]) + SW'(diff);

  assign in_ready_o  = (state_q == ST_IDLE) && !out_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign kind_o           = kind_q;
  assign decoded_symbol_o = dsym_q;
  assign code_o           = code_q;
  assign code_len_o       = clen_q;

  chc_ram #(.Depth(SYMBOLS), .Width(LW)) u_len_ram (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(len_wdata),
    .raddr_i(len_raddr), .rdata_o(len_rdata)
  );

  chc_ram #(.Depth(SYMBOLS), .Width(CodeW)) u_code_ram (
    .clk_i, .we_i(code_we), .waddr_i(code_waddr), .wdata_i(code_wdata),
    .raddr_i(sym_addr), .rdata_o(code_rdata)
  );

  chc_ram #(.Depth(SYMBOLS), .Width(SymW)) u_srt_ram (
    .clk_i, .we_i(srt_we), .waddr_i(placed_q[AW-1:0]), .wdata_i(SymW'(rd_sym_q)),
    .raddr_i(srt_raddr), .rdata_o(srt_rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    s_d         = s_q;
    rd_v_d      = 1'b0;
    rd_sym_d    = rd_sym_q;
    len_idx_d   = len_idx_q;
    cur_d       = cur_q;
    first_cur_d = first_cur_q;
    cnt_cur_d   = cnt_cur_q;
    base_cur_d  = base_cur_q;
    placed_d    = placed_q;
    gc_d        = gc_q;
    gb_d        = gb_q;
    enc_ok_d    = enc_ok_q;
    tab_we      = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    kind_d      = kind_q;
    dsym_d      = dsym_q;
    code_d      = code_q;
    clen_d      = clen_q;
    len_we      = 1'b0;
    len_waddr   = sym_addr;
    len_wdata   = (length_i <= LenW'(MaxCodeBits)) ? LW'(length_i) : '0;
    len_raddr   = sym_addr;
    code_we     = hit;
    code_waddr  = rd_sym_q;
    code_wdata  = cur_q;
    srt_we      = hit;
    srt_raddr   = pos_sum[AW-1:0];

    case (state_q)
      ST_CLEAR: begin
        len_we     = 1'b1;
        len_waddr  = clr_q;
        len_wdata  = '0;
        code_we    = 1'b1;
        code_waddr = clr_q;
        code_wdata = '0;
        clr_d      = clr_q + AW'(1);
        if (clr_q == AW'(SYMBOLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          case (op_e'(op_i))
            OP_LOAD: begin
              len_we = sym_ok;
            end
            OP_BUILD: begin
              state_d     = ST_SCAN;
              s_d         = '0;
              len_idx_d   = '0;
              cur_d       = '0;
              first_cur_d = '0;
              cnt_cur_d   = '0;
              base_cur_d  = '0;
              placed_d    = '0;
              gc_d        = '0;
              gb_d        = '0;
            end
            OP_ENCODE: begin
              state_d  = ST_ENC;
              enc_ok_d = sym_ok;
            end
            OP_DECODE: begin
              if (match) begin
                state_d = ST_DEC;
                gc_d    = '0;
                gb_d    = '0;
              end else if (gb_q == IW'(MaxCodeBits - 1)) begin
                gc_d        = '0;
                gb_d        = '0;
                out_valid_d = 1'b1;
                kind_d      = KIND_FAIL;
                dsym_d      = '0;
                code_d      = '0;
                clen_d      = '0;
              end else begin
                gc_d = gc_n;
                gb_d = gb_q + IW'(1);
              end
            end
            default: ;
          endcase
        end
      end
      ST_ENC: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        kind_d      = KIND_ENC;
        dsym_d      = '0;
        code_d      = (enc_ok_q && (len_rdata != '0)) ? code_rdata : '0;
        clen_d      = enc_ok_q ? LenW'(len_rdata) : '0;
      end
      ST_DEC: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
        kind_d      = KIND_SYM;
        dsym_d      = srt_rdata;
        code_d      = '0;
        clen_d      = '0;
      end
      ST_SCAN: begin
        len_raddr = s_q[AW-1:0];
        if (hit) begin
          if (cnt_cur_q == '0) begin
            first_cur_d = cur_q;
          end
          cur_d     = cur_q + CodeW'(1);
          cnt_cur_d = cnt_cur_q + CW'(1);
          placed_d  = placed_q + CW'(1);
        end
        if (s_q < n_eff) begin
          rd_v_d   = 1'b1;
          rd_sym_d = s_q[AW-1:0];
          s_d      = s_q + NW'(1);
        end else if (!rd_v_q) begin
          tab_we = 1'b1;
          if (len_idx_q == IW'(MaxCodeBits - 1)) begin
            state_d = ST_IDLE;
          end else begin
            len_idx_d   = len_idx_q + IW'(1);
            cur_d       = {cur_q[CodeW-2:0], 1'b0};
            s_d         = '0;
            base_cur_d  = placed_q;
            cnt_cur_d   = '0;
            first_cur_d = '0;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      num_q       <= NumSymRst;
      clr_q       <= '0;
      s_q         <= '0;
      rd_v_q      <= 1'b0;
      len_idx_q   <= '0;
      cnt_cur_q   <= '0;
      placed_q    <= '0;
      gc_q        <= '0;
      gb_q        <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MaxCodeBits; i++) begin
        first_q[i] <= '0;
        count_q[i] <= '0;
        base_q[i]  <= '0;
      end
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      s_q         <= s_d;
      rd_v_q      <= rd_v_d;
      len_idx_q   <= len_idx_d;
      cnt_cur_q   <= cnt_cur_d;
      placed_q    <= placed_d;
      gc_q        <= gc_d;
      gb_q        <= gb_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        num_q <= cfg_data_i;
      end
      if (tab_we) begin
        first_q[len_idx_q] <= (cnt_cur_q != '0) ? first_cur_q : '0;
        count_q[len_idx_q] <= cnt_cur_q;
        base_q[len_idx_q]  <= base_cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_sym_q    <= rd_sym_d;
    cur_q       <= cur_d;
    first_cur_q <= first_cur_d;
    base_cur_q  <= base_cur_d;
    enc_ok_q    <= enc_ok_d;
    kind_q      <= kind_d;
    dsym_q      <= dsym_d;
    code_q      <= code_d;
    clen_q      <= clen_d;
  end

  a_enc_no_sym: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q == KIND_ENC) |-> dsym_q == '0)
    else $error("encode word carries a symbol");

  a_dec_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (kind_q != KIND_ENC) |-> (code_q == '0) && (clen_q == '0))
    else $error("decode word carries a code");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> clen_q <= LenW'(MaxCodeBits))
    else $error("code length above maximum");

  a_placed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> NW'(placed_q) <= n_eff)
    else $error("build placed more symbols than in use");

endmodule

// ===== dv/canonical_huffman_codec_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_huffman_codec_chk
// Watches the input, result and register channels of the Huffman engine,
// tracks the length, code and sorted-symbol tables and the decode gathering
// on its own, and compares every result word against the oldest prediction.
// ----------------------------------------------------------------------------
module canonical_huffman_codec_chk
  import chc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         op_i,
  input  logic [SymW-1:0]    symbol_i,
  input  logic [LenW-1:0]    length_i,
  input  logic               bit_req_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [1:0]         kind_i,
  input  logic [SymW-1:0]    decoded_symbol_i,
  input  logic [CodeW-1:0]   code_i,
  input  logic [LenW-1:0]    code_len_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [NumSymW-1:0] cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);

  typedef struct packed {
    kind_e             kind;
    logic [SymW-1:0]   sym;
    logic [CodeW-1:0]  code;
    logic [LenW-1:0]   len;
  } huff_word_t;

  logic [LenW-1:0]    len_tab  [256];
  logic [CodeW-1:0]   code_tab [256];
  logic [SymW-1:0]    sorted   [256];
  logic [CodeW-1:0]   first_cw   [17];
  logic [8:0]         len_count  [17];
  logic [8:0]         len_base   [17];
  logic [CodeW-1:0]   gath_code;
  int                 gath_bits;
  logic [NumSymW-1:0] num_sym;
  huff_word_t         words_due[$];
  int                 n_enc, n_sym, n_fail;

  assign pending_o = words_due.size();

  function automatic int alphabet();
    return (num_sym < 256) ? int'(num_sym) : 256;
  endfunction

  function automatic void build_tables();
    int n, next, prev, placed, c;
    n = alphabet();
    next = 0;
    prev = 0;
    placed = 0;
    for (int l = 0; l <= MaxBitsDef; l++) begin
      first_cw[l] = '0;
      len_count[l] = '0;
      len_base[l] = '0;
    end
    for (int l = 1; l <= MaxBitsDef; l++) begin
      c = 0;
      len_base[l] = 9'(placed);
      for (int s = 0; s < n; s++) begin
        if (len_tab[s] == l) begin
          sorted[placed + c] = SymW'(s);
          c++;
        end
      end
      if (c != 0) begin
        next = (next << (l - prev)) & 16'hFFFF;
        first_cw[l] = CodeW'(next);
        len_count[l] = 9'(c);
        for (int i = 0; i < c; i++) begin
          code_tab[sorted[placed + i]] = CodeW'(next);
          next = (next + 1) & 16'hFFFF;
        end
        placed += c;
        prev = l;
      end
    end
    gath_code = '0;
    gath_bits = 0;
  endfunction

  function automatic void take_word(op_e op, int sym, int len, bit b);
    huff_word_t w;
    int f, pos;
    w = '0;
    case (op)
      OP_LOAD: begin
        if (sym < alphabet()) len_tab[sym] = (len <= MaxBitsDef) ? LenW'(len) : '0;
      end
      OP_BUILD: build_tables();
      OP_ENCODE: begin
        w.kind = KIND_ENC;
        if (sym < alphabet()) begin
          w.len = len_tab[sym];
          w.code = (len_tab[sym] != 0) ? code_tab[sym] : '0;
        end
        words_due.push_back(w);
      end
      default: begin
        gath_code = {gath_code[CodeW-2:0], b};
        gath_bits++;
        f = first_cw[gath_bits];
        if (gath_code >= f && (int'(gath_code) - f) < len_count[gath_bits]) begin
          pos = len_base[gath_bits] + int'(gath_code) - f;
          w.kind = KIND_SYM;
          w.sym = sorted[pos];
          gath_code = '0;
          gath_bits = 0;
          words_due.push_back(w);
        end else if (gath_bits >= MaxBitsDef) begin
          w.kind = KIND_FAIL;
          gath_code = '0;
          gath_bits = 0;
          words_due.push_back(w);
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    huff_word_t exp_w;
    if (!rst_ni) begin
      for (int s = 0; s < 256; s++) begin
        len_tab[s] = '0;
        code_tab[s] = '0;
        sorted[s] = '0;
      end
      for (int l = 0; l <= MaxBitsDef; l++) begin
        first_cw[l] = '0;
        len_count[l] = '0;
        len_base[l] = '0;
      end
      gath_code = '0;
      gath_bits = 0;
      num_sym = NumSymRst;
      errors_o = 0;
      n_enc = 0;
      n_sym = 0;
      n_fail = 0;
      words_due.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (words_due.size() == 0) begin
          $display("%0t: unexpected word kind=%0d sym=%0d code=%h len=%0d", $time,
                   kind_i, decoded_symbol_i, code_i, code_len_i);
          errors_o++;
        end else begin
          exp_w = words_due.pop_front();
          if (kind_i != exp_w.kind || decoded_symbol_i != exp_w.sym ||
              code_i != exp_w.code || code_len_i != exp_w.len) begin
            $display("%0t: mismatch expected kind=%0d sym=%0d code=%h len=%0d", $time,
                     exp_w.kind, exp_w.sym, exp_w.code, exp_w.len);
            $display("%0t:          actual   kind=%0d sym=%0d code=%h len=%0d", $time,
                     kind_i, decoded_symbol_i, code_i, code_len_i);
            errors_o++;
          end
          case (exp_w.kind)
            KIND_ENC: n_enc++;
            KIND_SYM: n_sym++;
            default:  n_fail++;
          endcase
        end
      end
      if (cfg_valid_i && cfg_ready_i) num_sym = cfg_data_i;
      if (in_valid_i && in_ready_i)
        take_word(op_e'(op_i), int'(symbol_i), int'(length_i), bit_req_i);
    end
  end

endmodule

// ===== dv/canonical_huffman_codec_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_huffman_codec_tb
// Drives length loads, table builds, encodes and bit-serial decodes under
// several alphabet sizes with random idling on both sides; the checker
// predicts and compares the results.
// ----------------------------------------------------------------------------
module canonical_huffman_codec_tb;
  import chc_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         op_i = OP_LOAD;
  logic [SymW-1:0]    symbol_i = '0;
  logic [LenW-1:0]    length_i = '0;
  logic               bit_req_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic [1:0]         kind_o;
  logic [SymW-1:0]    decoded_symbol_o;
  logic [CodeW-1:0]   code_o;
  logic [LenW-1:0]    code_len_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [NumSymW-1:0] cfg_data_i = '0;

  int  errors, pending;
  int  words_sent = 0;
  int  hold_cnt = 0;
  int  idle_cycles = 0;
  int  phases = 0;
  bit  quiet = 1'b0;

  canonical_huffman_codec uut (.*);

  canonical_huffman_codec_chk chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .op_i, .symbol_i,
    .length_i, .bit_req_i, .out_valid_i(out_valid_o), .out_ready_i,
    .kind_i(kind_o), .decoded_symbol_i(decoded_symbol_o), .code_i(code_o),
    .code_len_i(code_len_o), .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // entered at a falling edge; returns at the falling edge after acceptance
  task automatic put_word(op_e op, int sym, int len, bit b);
    if (!quiet && $urandom_range(0, 6) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= op;
    symbol_i <= sym[SymW-1:0];
    length_i <= len[LenW-1:0];
    bit_req_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic set_alphabet(int n);
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (4300) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= n[NumSymW-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_code(int s);
    for (int i = int'(chk.len_tab[s]) - 1; i >= 0; i--)
      put_word(OP_DECODE, 0, 0, chk.code_tab[s][i]);
  endtask

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt > 0) begin
        out_ready_i <= 1'b0;
        hold_cnt--;
      end else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 14) - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("canonical_huffman_codec regression: fail");
      $finish;
    end
  end

  initial begin
    int n, r, s, fixed_len;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every operation, clamped and unused lengths
    put_word(OP_LOAD, 0, 2, 0);
    put_word(OP_LOAD, 1, 2, 0);
    put_word(OP_LOAD, 2, 3, 0);
    put_word(OP_LOAD, 3, 3, 0);
    put_word(OP_LOAD, 4, 3, 0);
    put_word(OP_LOAD, 255, 16, 0);
    put_word(OP_LOAD, 7, 17, 0);
    put_word(OP_LOAD, 9, 31, 0);
    put_word(OP_LOAD, 10, 0, 0);
    put_word(OP_BUILD, 0, 0, 0);
    put_word(OP_ENCODE, 0, 0, 0);
    put_word(OP_ENCODE, 2, 0, 0);
    put_word(OP_ENCODE, 255, 0, 0);
    put_word(OP_ENCODE, 7, 0, 0);
    put_word(OP_ENCODE, 9, 0, 0);
    put_word(OP_ENCODE, 200, 0, 0);
    send_code(2);
    send_code(255);
    send_code(0);

    // random phases over alphabet sizes
    while (words_sent < 600) begin
      r = $urandom_range(0, 9);
      n = (phases == 0) ? 1 : (phases == 1) ? 256 :
          (r == 0) ? 256 : (r == 1) ? 1 : $urandom_range(2, 24);
      set_alphabet(n);
      fixed_len = $clog2(n) < 1 ? 1 : $clog2(n);
      r = $urandom_range(0, 2);
      for (int i = 0; i < ((n == 256) ? 20 : n); i++) begin
        s = (n == 256) ? $urandom_range(0, 255) : i;
        put_word(OP_LOAD, s, (r == 0) ? fixed_len : $urandom_range(1, 8), 0);
      end
      put_word(OP_BUILD, 0, 0, 0);
      if (phases == 2) hold_cnt = 300;
      for (int k = 0; k < 40; k++) begin
        r = $urandom_range(0, 19);
        if (r < 6) begin
          put_word(OP_ENCODE, $urandom_range(0, 255), 0, 0);
        end else if (r < 16) begin
          s = $urandom_range(0, n - 1);
          if (chk.len_tab[s] != 0) send_code(s);
          else put_word(OP_DECODE, 0, 0, $urandom_range(0, 1));
        end else if (r < 18) begin
          repeat ($urandom_range(1, 4)) put_word(OP_DECODE, 0, 0, $urandom_range(0, 1));
        end else begin
          put_word(OP_LOAD, $urandom_range(0, 255), $urandom_range(0, 31), 0);
        end
      end
      if (words_sent > 480) quiet = 1'b1;
      phases++;
    end

    in_valid_i <= 1'b0;
    quiet = 1'b1;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("covered %0d words in %0d alphabet phases", words_sent, phases);
    $display("results: %0d encodes, %0d decoded symbols, %0d decode failures",
             chk.n_enc, chk.n_sym, chk.n_fail);
    if (errors == 0)
      $display("canonical_huffman_codec regression: pass");
    else
      $display("canonical_huffman_codec regression: fail");
    $finish;
  end

endmodule
